### src/svi_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the SVI implied volatility unit.
// No dependencies; used by svi_slice_mem, svi_div, the unit and the checker.
package svi_pkg;

   localparam int MAX_SLICES_DEF = 16;

   localparam logic [31:0]        SPOT_RESET = 32'h0001_0000;
   localparam logic [31:0]        LN2_Q32    = 32'hB172_17F8;
   localparam logic signed [31:0] ONE_Q24    = 32'sh0100_0000;

   // iterative unit sizes
   localparam int DIV_BITS  = 40;
   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] WEIGHT_STEPS = 6'd24;
   localparam logic [DIV_CNT_W-1:0] VAR_STEPS    = 6'd40;

   // register index, taken from csr_paddr[2]
   localparam logic REG_SPOT        = 1'b0;
   localparam logic REG_SLICE_COUNT = 1'b1;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_QUERY = 2'd1,
      ST_BAD_SLICE = 2'd2,
      ST_BAD_VAR   = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_FIRST, S_LAST, S_SEARCH, S_CHECK, S_LOGWAIT, S_KSUM,
      S_ZDIFF, S_AZSQ, S_SIGSQ, S_ROOT, S_ROOTWAIT, S_BT, S_WSUM,
      S_WEIGHT, S_WTWAIT, S_DMUL1, S_DMUL2, S_DSUM, S_FINAL, S_VDIV,
      S_VSQRT, S_DONE
   } seq_state_type;

   typedef struct packed {
      logic [31:0]        expiry;
      logic signed [31:0] level;
      logic signed [31:0] slope;
      logic signed [31:0] skew;
      logic signed [31:0] shift;
      logic signed [31:0] curvature;
   } slice_type;

   typedef struct packed {
      logic                 start;
      logic [31:0]          r0;
      logic [31:0]          den;
      logic [DIV_BITS-1:0]  bits;
      logic [DIV_CNT_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quot;
   } div_rsp_type;

   function automatic logic slice_ok(slice_type s);
      slice_ok = (s.expiry != 32'h0) && !s.slope[31] && (s.curvature > 32'sd0) &&
                 (s.skew < ONE_Q24) && (s.skew > -ONE_Q24);
   endfunction

endpackage

### src/svi_slice_mem.sv
`timescale 1ns / 1ps
// Slice table: one synchronous memory of slice records, one write and one read port.
// Uses svi_pkg::slice_type.
module svi_slice_mem #(
   parameter int MAX_SLICES = svi_pkg::MAX_SLICES_DEF,
   parameter int AW         = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  svi_pkg::slice_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output svi_pkg::slice_type  rd_data
);

   svi_pkg::slice_type mem [MAX_SLICES];
   svi_pkg::slice_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/svi_log2.sv
`timescale 1ns / 1ps
// Iterative log2 of a nonzero 32-bit integer, result Q5.24 (29 bits).
// Five normalize steps, then 24 squaring steps of a Q1.31 mantissa. No package use.
module svi_log2 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] x,
   output logic        done,
   output logic [28:0] val
);

   localparam logic [4:0] LAST_STEP = 5'd28;
   localparam logic [4:0] NORM_STEPS = 5'd5;

   logic        busy_ff, done_ff;
   logic [4:0]  step_ff;
   logic [31:0] m_ff, m_in;
   logic [4:0]  e_ff, e_in;
   logic [23:0] frac_ff, frac_in;
   logic [4:0]  norm_sh;
   logic [63:0] sq;

   assign norm_sh = 5'd16 >> step_ff[2:0];
   assign sq      = m_ff * m_ff;

   always_comb begin
      m_in    = m_ff;
      e_in    = e_ff;
      frac_in = frac_ff;
      if (step_ff < NORM_STEPS) begin
         // shift up when the top norm_sh bits are all zero
         if ((m_ff & ~(32'hFFFF_FFFF >> norm_sh)) == 32'h0) begin
            m_in = m_ff << norm_sh;
            e_in = e_ff - norm_sh;
         end
      end else if (sq[63]) begin
         m_in    = sq[63:32];
         frac_in = {frac_ff[22:0], 1'b1};
      end else begin
         m_in    = sq[62:31];
         frac_in = {frac_ff[22:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 5'd1;
         if (step_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         m_ff    <= x;
         e_ff    <= 5'd31;
         frac_ff <= '0;
      end else if (busy_ff) begin
         m_ff    <= m_in;
         e_ff    <= e_in;
         frac_ff <= frac_in;
      end
   end

   assign done = done_ff;
   assign val  = {e_ff, frac_ff};

endmodule

### src/svi_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. Starts from a remainder below the
// divisor and shifts in dividend bits MSB first. Uses svi_pkg div request/response types.
module svi_div (
   input  logic                 clock,
   input  logic                 reset,
   input  svi_pkg::div_req_type req,
   output svi_pkg::div_rsp_type rsp
);

   localparam int DB = svi_pkg::DIV_BITS;
   localparam int CW = svi_pkg::DIV_CNT_W;

   logic          busy_ff, done_ff;
   logic [CW-1:0] cnt_ff;
   logic [31:0]   rem_ff, den_ff;
   logic [DB-1:0] bits_ff, quot_ff;
   logic [32:0]   trial, diff;
   logic          ge;

   assign trial = {rem_ff, bits_ff[DB-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= req.steps;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff  <= req.r0;
         den_ff  <= req.den;
         bits_ff <= req.bits;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff[31:0] : trial[31:0];
         bits_ff <= {bits_ff[DB-2:0], 1'b0};
         quot_ff <= {quot_ff[DB-2:0], ge};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

### src/svi_sqrt.sv
`timescale 1ns / 1ps
// Floor square root of a 64-bit value, digit by digit, one root bit per cycle.
// No package use.
module svi_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] arg,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff, done_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] x_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;
   logic [35:0] rem2, trial, diff;
   logic        ge;

   assign rem2  = {rem_ff, x_ff[63:62]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign diff  = rem2 - trial;
   assign ge    = rem2 >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd32;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= arg;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         x_ff    <= {x_ff[61:0], 2'b00};
         rem_ff  <= ge ? diff[33:0] : rem2[33:0];
         root_ff <= {root_ff[30:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### src/svi_surface_implied_vol_unit.sv
`timescale 1ns / 1ps
// Raw-SVI implied volatility unit. A load writes the slice on accept and reports
// through the DONE state. A query takes longer with two interpolated slices than
// with one, plus the bracket search; the 32-step root and 40-step divide dominate.
// One request is in flight at a time; a finished result waits in the output register.
// Reset (synchronous) clears control, spot to 1.0 and slice_count to 0; the slice
// table is not cleared. Depends on svi_pkg and the svi_ submodules.
module svi_surface_implied_vol_unit #(
   parameter int MAX_SLICES = svi_pkg::MAX_SLICES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // req_tuser: [0] req_type
   input  logic [0:0]   req_tuser,
   // req_tdata: slot[3:0] expiry_in[35:4] level_in[67:36] slope_in[99:68]
   //   skew_in[131:100] shift_in[163:132] curvature_in[195:164] strike[227:196]
   //   maturity[259:228], zero pad to 264
   input  logic [263:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // rsp_tdata: implied_vol[31:0]
   output logic [31:0]  rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int AW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
   localparam int CW = $clog2(MAX_SLICES + 1);

   // request fields
   logic                req_kind;
   logic [3:0]          req_slot;
   svi_pkg::slice_type  req_slice;
   logic [31:0]         req_strike, req_mat;

   assign req_kind            = req_tuser[0];
   assign req_slot            = req_tdata[3:0];
   assign req_slice.expiry    = req_tdata[35:4];
   assign req_slice.level     = req_tdata[67:36];
   assign req_slice.slope     = req_tdata[99:68];
   assign req_slice.skew      = req_tdata[131:100];
   assign req_slice.shift     = req_tdata[163:132];
   assign req_slice.curvature = req_tdata[195:164];
   assign req_strike          = req_tdata[227:196];
   assign req_mat             = req_tdata[259:228];

   // registers
   svi_pkg::seq_state_type state_ff, state_in;
   logic [31:0]         spot_ff;
   logic [4:0]          count_ff;
   logic [31:0]         mat_ff;
   logic [CW-1:0]       n_ff, idx_ff;
   svi_pkg::slice_type  slc_lo_ff, slc_hi_ff;
   logic                interp_ff, pass_ff;
   logic signed [33:0]  k_ff, z_ff, t_ff;
   logic [63:0]         acc_ff;
   logic signed [47:0]  w_ff, w1_ff;
   logic [23:0]         weight_ff;
   logic signed [67:0]  mul_ff;
   logic [31:0]         res_vol_ff;
   svi_pkg::status_type res_status_ff;
   logic                rsp_valid_ff;
   logic [31:0]         rsp_vol_ff;
   svi_pkg::status_type rsp_status_ff;

   // datapath nets
   logic                accept, q_bad, rsp_free;
   logic [CW-1:0]       n_cap, n_m1, idx_nx;
   svi_pkg::slice_type  mem_rd_data, cur;
   logic                mem_wr_en, mem_rd_en;
   logic [AW-1:0]       mem_rd_addr;
   logic                at_first, at_last, found, chk_ok;
   logic                lg_start, lg_k_done, lg_s_done;
   logic [28:0]         lg_k_val, lg_s_val;
   svi_pkg::div_req_type div_req;
   svi_pkg::div_rsp_type div_rsp;
   logic                sq_start, sq_done;
   logic [63:0]         sq_arg;
   logic [31:0]         sq_root;
   logic                mul_en;
   logic signed [33:0]  mul_a, mul_b, az;
   logic signed [67:0]  k_sum;
   logic [34:0]         tsum;
   logic signed [47:0]  wv;
   logic signed [48:0]  d;
   logic [31:0]         div_sel;
   logic                w_nonpos, w_sat;
   logic                res_load;
   logic [31:0]         res_vol;
   svi_pkg::status_type res_status;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign q_bad    = (req_strike == 32'h0) || (req_mat == 32'h0) ||
                     (spot_ff == 32'h0) || (count_ff == 5'd0);
   assign n_cap    = (32'(count_ff) > MAX_SLICES) ? CW'(MAX_SLICES) : CW'(count_ff);
   assign n_m1     = n_ff - 1'b1;
   assign idx_nx   = idx_ff + 1'b1;
   assign cur      = pass_ff ? slc_hi_ff : slc_lo_ff;

   assign at_first = mat_ff <= slc_lo_ff.expiry;
   assign at_last  = mat_ff >= mem_rd_data.expiry;
   assign found    = (mat_ff < mem_rd_data.expiry) || (idx_ff == n_m1);
   assign chk_ok   = svi_pkg::slice_ok(slc_lo_ff) &&
                     (!interp_ff || svi_pkg::slice_ok(slc_hi_ff));

   assign az       = z_ff[33] ? -z_ff : z_ff;
   assign k_sum    = mul_ff + 68'sh8000_0000;
   assign tsum     = 35'($signed(mul_ff[57:24])) + 35'(sq_root);
   assign wv       = 48'(cur.level) + 48'(mul_ff[63:24]);
   assign d        = 49'(w_ff) - 49'(w1_ff);
   assign div_sel  = interp_ff ? mat_ff : slc_lo_ff.expiry;
   assign w_nonpos = w_ff[47] || (w_ff == 48'sh0);
   assign w_sat    = $unsigned(w_ff) >= {div_sel, 16'h0};

   // one request at a time, so a table read never overlaps a table write
   svi_slice_mem #(.MAX_SLICES(MAX_SLICES), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (AW'(req_slot)),
      .wr_data (req_slice),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   svi_log2 u_log_k (
      .clock (clock), .reset (reset), .start (lg_start), .x (req_strike),
      .done (lg_k_done), .val (lg_k_val)
   );

   svi_log2 u_log_s (
      .clock (clock), .reset (reset), .start (lg_start), .x (spot_ff),
      .done (lg_s_done), .val (lg_s_val)
   );

   svi_div u_div (.clock (clock), .reset (reset), .req (div_req), .rsp (div_rsp));

   svi_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (sq_start), .arg (sq_arg),
      .done (sq_done), .root (sq_root)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         svi_pkg::S_IDLE: begin
            if (accept) begin
               if (req_kind == svi_pkg::REQ_LOAD || q_bad) state_in = svi_pkg::S_DONE;
               else state_in = svi_pkg::S_FIRST;
            end
         end
         svi_pkg::S_FIRST: state_in = svi_pkg::S_LAST;
         svi_pkg::S_LAST: begin
            if (at_first || at_last) state_in = svi_pkg::S_CHECK;
            else state_in = svi_pkg::S_SEARCH;
         end
         svi_pkg::S_SEARCH: if (found) state_in = svi_pkg::S_CHECK;
         svi_pkg::S_CHECK: begin
            state_in = chk_ok ? svi_pkg::S_LOGWAIT : svi_pkg::S_DONE;
         end
         svi_pkg::S_LOGWAIT: if (lg_k_done && lg_s_done) state_in = svi_pkg::S_KSUM;
         svi_pkg::S_KSUM:    state_in = svi_pkg::S_ZDIFF;
         svi_pkg::S_ZDIFF:   state_in = svi_pkg::S_AZSQ;
         svi_pkg::S_AZSQ:    state_in = svi_pkg::S_SIGSQ;
         svi_pkg::S_SIGSQ:   state_in = svi_pkg::S_ROOT;
         svi_pkg::S_ROOT:    state_in = svi_pkg::S_ROOTWAIT;
         svi_pkg::S_ROOTWAIT: if (sq_done) state_in = svi_pkg::S_BT;
         svi_pkg::S_BT:      state_in = svi_pkg::S_WSUM;
         svi_pkg::S_WSUM: begin
            if (interp_ff && !pass_ff) state_in = svi_pkg::S_ZDIFF;
            else if (interp_ff) state_in = svi_pkg::S_WEIGHT;
            else state_in = svi_pkg::S_FINAL;
         end
         svi_pkg::S_WEIGHT: begin
            state_in = (mat_ff >= slc_lo_ff.expiry) ? svi_pkg::S_WTWAIT : svi_pkg::S_DMUL1;
         end
         svi_pkg::S_WTWAIT: if (div_rsp.done) state_in = svi_pkg::S_DMUL1;
         svi_pkg::S_DMUL1:  state_in = svi_pkg::S_DMUL2;
         svi_pkg::S_DMUL2:  state_in = svi_pkg::S_DSUM;
         svi_pkg::S_DSUM:   state_in = svi_pkg::S_FINAL;
         svi_pkg::S_FINAL: begin
            state_in = (w_nonpos || w_sat) ? svi_pkg::S_DONE : svi_pkg::S_VDIV;
         end
         svi_pkg::S_VDIV:  if (div_rsp.done) state_in = svi_pkg::S_VSQRT;
         svi_pkg::S_VSQRT: if (sq_done) state_in = svi_pkg::S_DONE;
         svi_pkg::S_DONE:  if (rsp_free) state_in = svi_pkg::S_IDLE;
         default: state_in = svi_pkg::S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready    = 1'b0;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      lg_start      = 1'b0;
      div_req       = '0;
      sq_start      = 1'b0;
      sq_arg        = '0;
      mul_en        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      res_load      = 1'b0;
      res_vol       = '0;
      res_status    = svi_pkg::ST_OK;
      case (state_ff)
         svi_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               if (req_kind == svi_pkg::REQ_LOAD) begin
                  mem_wr_en = 32'(req_slot) < MAX_SLICES;
                  res_load  = 1'b1;
               end else if (q_bad) begin
                  res_load   = 1'b1;
                  res_status = svi_pkg::ST_BAD_QUERY;
               end else begin
                  lg_start  = 1'b1;
                  mem_rd_en = 1'b1;
               end
            end
         end
         svi_pkg::S_FIRST: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = n_m1[AW-1:0];
         end
         svi_pkg::S_LAST: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(1);
         end
         svi_pkg::S_SEARCH: begin
            mem_rd_en   = !found;
            mem_rd_addr = idx_nx[AW-1:0];
         end
         svi_pkg::S_CHECK: begin
            if (!chk_ok) begin
               res_load   = 1'b1;
               res_status = svi_pkg::ST_BAD_SLICE;
            end
         end
         svi_pkg::S_LOGWAIT: begin
            mul_en = 1'b1;
            mul_a  = 34'($signed({1'b0, lg_k_val})) - 34'($signed({1'b0, lg_s_val}));
            mul_b  = 34'(svi_pkg::LN2_Q32);
         end
         svi_pkg::S_AZSQ: begin
            mul_en = 1'b1;
            mul_a  = az;
            mul_b  = az;
         end
         svi_pkg::S_SIGSQ: begin
            mul_en = 1'b1;
            mul_a  = 34'(cur.curvature);
            mul_b  = 34'(cur.curvature);
         end
         svi_pkg::S_ROOT: begin
            sq_start = 1'b1;
            sq_arg   = acc_ff + mul_ff[63:0];
            mul_en   = 1'b1;
            mul_a    = 34'(cur.skew);
            mul_b    = z_ff;
         end
         svi_pkg::S_BT: begin
            mul_en = 1'b1;
            mul_a  = 34'(cur.slope);
            mul_b  = t_ff;
         end
         svi_pkg::S_WEIGHT: begin
            div_req.start = mat_ff >= slc_lo_ff.expiry;
            div_req.r0    = mat_ff - slc_lo_ff.expiry;
            div_req.den   = slc_hi_ff.expiry - slc_lo_ff.expiry;
            div_req.steps = svi_pkg::WEIGHT_STEPS;
         end
         svi_pkg::S_DMUL1: begin
            mul_en = 1'b1;
            mul_a  = 34'($signed(d[48:24]));
            mul_b  = 34'(weight_ff);
         end
         svi_pkg::S_DMUL2: begin
            mul_en = 1'b1;
            mul_a  = 34'(d[23:0]);
            mul_b  = 34'(weight_ff);
         end
         svi_pkg::S_FINAL: begin
            if (w_nonpos) begin
               res_load   = 1'b1;
               res_status = svi_pkg::ST_BAD_VAR;
            end else if (w_sat) begin
               res_load = 1'b1;
               res_vol  = 32'hFFFF_FFFF;
            end else begin
               // quotient of w*2^24/T; top of the dividend is already below T
               div_req.start = 1'b1;
               div_req.r0    = w_ff[47:16];
               div_req.den   = div_sel;
               div_req.bits  = {w_ff[15:0], 24'h0};
               div_req.steps = svi_pkg::VAR_STEPS;
            end
         end
         svi_pkg::S_VDIV: begin
            sq_start = div_rsp.done;
            sq_arg   = {div_rsp.quot, 24'h0};
         end
         svi_pkg::S_VSQRT: begin
            res_load = sq_done;
            res_vol  = sq_root;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svi_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         spot_ff      <= svi_pkg::SPOT_RESET;
         count_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == svi_pkg::S_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[2])
               svi_pkg::REG_SPOT:        spot_ff  <= csr_pwdata;
               svi_pkg::REG_SLICE_COUNT: count_ff <= csr_pwdata[4:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) mul_ff <= mul_a * mul_b;
      if (res_load) begin
         res_vol_ff    <= res_vol;
         res_status_ff <= res_status;
      end
      if (state_ff == svi_pkg::S_DONE && rsp_free) begin
         rsp_vol_ff    <= res_vol_ff;
         rsp_status_ff <= res_status_ff;
      end
      case (state_ff)
         svi_pkg::S_IDLE: begin
            mat_ff    <= req_mat;
            n_ff      <= n_cap;
            interp_ff <= 1'b0;
            pass_ff   <= 1'b0;
         end
         svi_pkg::S_FIRST: slc_lo_ff <= mem_rd_data;
         svi_pkg::S_LAST: begin
            idx_ff <= CW'(1);
            if (!at_first && at_last) slc_lo_ff <= mem_rd_data;
            if (!at_first && !at_last) interp_ff <= 1'b1;
         end
         svi_pkg::S_SEARCH: begin
            if (found) slc_hi_ff <= mem_rd_data;
            else begin
               slc_lo_ff <= mem_rd_data;
               idx_ff    <= idx_nx;
            end
         end
         svi_pkg::S_KSUM:  k_ff <= k_sum[65:32];
         svi_pkg::S_ZDIFF: z_ff <= k_ff - 34'(cur.shift);
         svi_pkg::S_SIGSQ: acc_ff <= mul_ff[63:0];
         svi_pkg::S_ROOTWAIT: begin
            // clamp negative t to zero
            t_ff <= tsum[34] ? 34'sh0 : $signed(tsum[33:0]);
         end
         svi_pkg::S_WSUM: begin
            if (interp_ff && !pass_ff) begin
               w1_ff   <= wv;
               pass_ff <= 1'b1;
            end else begin
               w_ff <= wv;
            end
         end
         svi_pkg::S_WEIGHT: if (mat_ff < slc_lo_ff.expiry) weight_ff <= '0;
         svi_pkg::S_WTWAIT: weight_ff <= div_rsp.quot[23:0];
         svi_pkg::S_DMUL2:  w_ff <= w1_ff + mul_ff[47:0];
         svi_pkg::S_DSUM:   w_ff <= w_ff + 48'(mul_ff[47:24]);
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_vol_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == svi_pkg::REG_SLICE_COUNT) ?
                       {27'h0, count_ff} : spot_ff;

endmodule

### src/svi_checker.sv
`timescale 1ns / 1ps
// Port-level checks for svi_surface_implied_vol_unit, attached with bind.
// Uses svi_pkg status codes.
module svi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != svi_pkg::ST_OK) |-> rsp_tdata == 32'h0)
      else $error("nonzero volatility with error status");

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in flight");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind svi_surface_implied_vol_unit svi_checker u_svi_checker (.*);
